// ===== hw/rtl/lznt_pkg.sv =====
// Shared types and constants for the LZNT1 decompressor.
`default_nettype none
package lznt_pkg;

   localparam int HIST_DEPTH = 4096;
   localparam int HIST_AW    = 12;
   localparam int IQ_DEPTH   = 4;
   localparam int OQ_DEPTH   = 4;

   localparam logic [2:0] ST_BYTE      = 3'd0;
   localparam logic [2:0] ST_UNIT_END  = 3'd1;
   localparam logic [2:0] ST_CHUNK_END = 3'd2;
   localparam logic [2:0] ST_TOKEN_END = 3'd3;
   localparam logic [2:0] ST_OFFSET    = 3'd4;
   localparam logic [2:0] ST_LENGTH    = 3'd5;
   localparam logic [2:0] ST_FULL      = 3'd6;
   localparam logic [2:0] ST_BUSY      = 3'd7;

   typedef enum logic [5:0] {
      PH_HDR_LO = 6'b000001,
      PH_HDR_HI = 6'b000010,
      PH_FLAG   = 6'b000100,
      PH_ITEM   = 6'b001000,
      PH_TOK_HI = 6'b010000,
      PH_RAW    = 6'b100000
   } phase_type;

   // classified input item
   typedef struct packed {
      logic       is_pull;
      logic [7:0] data;
      logic       last;
   } item_type;

   // engine to back end: one processed item
   typedef struct packed {
      logic               valid;
      logic               has_res;
      logic [2:0]         st;
      logic               two;       // trailing unit-end result
      logic               emit;      // byte goes to history
      logic               from_mem;  // byte comes from history
      logic [7:0]         lit;
      logic [HIST_AW-1:0] wr_addr;
      logic [HIST_AW-1:0] rd_addr;
   } job_type;

endpackage
`default_nettype wire

// ===== hw/rtl/lznt_front.sv =====
// Input queue: takes transfers and classifies them for the engine.
`default_nettype none
module lznt_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_func,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_in_last,
   output logic                    item_valid,
   output lznt_pkg::item_type      item,
   input  wire logic               item_take
);
   import lznt_pkg::*;

   localparam int PW = $clog2(IQ_DEPTH);

   item_type        q_ff [IQ_DEPTH];
   logic [PW-1:0]   wp_ff, rp_ff;
   logic [PW:0]     cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign req_full   = (cnt_ff == (PW+1)'(IQ_DEPTH));
   assign do_push    = req_push && !req_full;
   assign item_valid = (cnt_ff != '0);
   assign do_pop     = item_take && item_valid;
   assign item       = q_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) wp_ff <= wp_ff + 1'b1;
         if (do_pop) rp_ff <= rp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= '{is_pull: req_func, data: req_in_byte, last: req_in_last};
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/lznt_engine.sv =====
// Parse engine: chunk headers, flags, tokens and copy bookkeeping.
`default_nettype none
module lznt_engine #(
   parameter int CW = 18
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  lznt_pkg::item_type      it,
   input  wire logic [CW-1:0]      limit,
   output lznt_pkg::job_type       job
);
   import lznt_pkg::*;

   logic [HIST_AW-1:0] wr_ff, wr_in;
   logic [CW-1:0]      uc_ff, uc_in;
   logic [12:0]        cp_ff, cp_in, cl_ff, cl_in, coff_ff, coff_in, cleft_ff, cleft_in;
   phase_type          ph_ff, ph_in;
   logic [7:0]         fb_ff, fb_in, tl_ff, tl_in;
   logic [2:0]         fi_ff, fi_in;
   logic               raw_ff, raw_in, err_ff, err_in, ie_ff, ie_in;

   logic [12:0] cl_dec, cp_inc, cpm1, len;
   logic [3:0]  blen, shift;
   logic [15:0] p;
   logic [13:0] off;
   logic [CW:0] need;
   phase_type   ni_ph;
   logic [2:0]  ni_fi;
   logic        full, clr, failed;

   assign cl_dec = (cl_ff != '0) ? cl_ff - 1'b1 : '0;
   assign cp_inc = (cp_ff != 13'h1FFF) ? cp_ff + 1'b1 : cp_ff;
   assign full   = (uc_ff >= limit);

   // token split by chunk position
   assign cpm1 = cp_ff - 1'b1;
   always_comb begin
      blen = '0;
      for (int i = 0; i < 13; i++) begin
         if (cpm1[i]) blen = 4'(i + 1);
      end
   end
   assign shift = (blen > 4'd4) ? blen - 4'd4 : 4'd0;
   assign p     = {it.data, tl_ff};
   assign off   = 14'(p >> (4'd12 - shift)) + 14'd1;
   assign len   = {1'b0, p[11:0] & (12'hFFF >> shift)} + 13'd3;
   assign need  = {1'b0, uc_ff} + (CW+1)'(len);

   always_comb begin
      if (fi_ff == 3'd7) begin
         ni_fi = '0;
         ni_ph = PH_FLAG;
      end else begin
         ni_fi = fi_ff + 1'b1;
         ni_ph = PH_ITEM;
      end
      if (cl_dec == '0) ni_ph = PH_HDR_LO;
   end

   always_comb begin
      wr_in = wr_ff; uc_in = uc_ff; cp_in = cp_ff; cl_in = cl_ff;
      coff_in = coff_ff; cleft_in = cleft_ff; ph_in = ph_ff; fb_in = fb_ff;
      tl_in = tl_ff; fi_in = fi_ff; raw_in = raw_ff; err_in = err_ff; ie_in = ie_ff;
      job = '0;
      job.valid = fire;
      job.wr_addr = wr_ff;
      job.rd_addr = wr_ff - coff_ff[HIST_AW-1:0];
      clr = 1'b0;
      failed = 1'b0;
      if (fire) begin
         if (it.is_pull) begin
            if (!err_ff && cleft_ff != '0) begin
               job.emit = 1'b1; job.from_mem = 1'b1;
               job.has_res = 1'b1; job.st = ST_BYTE;
               wr_in = wr_ff + 1'b1; uc_in = uc_ff + 1'b1; cp_in = cp_inc;
               cleft_in = cleft_ff - 1'b1;
               if (cleft_ff == 13'd1 && ie_ff) begin
                  job.two = 1'b1;
                  clr = 1'b1;
               end
            end
         end else if (err_ff) begin
            if (it.last) clr = 1'b1;
         end else if (cleft_ff != '0) begin
            job.has_res = 1'b1; job.st = ST_BUSY;
         end else begin
            unique case (ph_ff)
               PH_HDR_LO: begin
                  if (it.last) begin
                     job.has_res = 1'b1; job.st = ST_UNIT_END; clr = 1'b1;
                  end else begin
                     tl_in = it.data; ph_in = PH_HDR_HI;
                  end
               end
               PH_HDR_HI: begin
                  if ({it.data[3:0], tl_ff} == 12'd0) begin
                     job.has_res = 1'b1; job.st = ST_UNIT_END;
                     if (it.last) clr = 1'b1; else err_in = 1'b1;
                  end else if (it.last) begin
                     job.has_res = 1'b1; job.st = ST_CHUNK_END; clr = 1'b1;
                  end else begin
                     cl_in  = {1'b0, it.data[3:0], tl_ff} + 13'd1;
                     raw_in = !it.data[7] && ({it.data[3:0], tl_ff} == 12'hFFF);
                     cp_in  = '0;
                     ph_in  = raw_in ? PH_RAW : PH_FLAG;
                  end
               end
               default: begin
                  cl_in = cl_dec;
                  if (it.last && cl_dec != '0) begin
                     job.has_res = 1'b1; job.st = ST_CHUNK_END; clr = 1'b1;
                  end else begin
                     case (ph_ff)
                        PH_FLAG: begin
                           fb_in = it.data; fi_in = '0;
                           ph_in = (cl_dec == '0) ? PH_HDR_LO : PH_ITEM;
                        end
                        PH_ITEM: begin
                           if (!fb_ff[fi_ff]) begin
                              if (full) begin
                                 failed = 1'b1; job.st = ST_FULL;
                              end else begin
                                 job.emit = 1'b1; job.lit = it.data;
                                 job.has_res = 1'b1; job.st = ST_BYTE;
                                 wr_in = wr_ff + 1'b1; uc_in = uc_ff + 1'b1; cp_in = cp_inc;
                                 fi_in = ni_fi; ph_in = ni_ph;
                              end
                           end else if (cl_dec == '0) begin
                              failed = 1'b1; job.st = ST_TOKEN_END;
                           end else begin
                              tl_in = it.data; ph_in = PH_TOK_HI;
                           end
                        end
                        PH_TOK_HI: begin
                           if (cp_ff == '0 || off > {1'b0, cp_ff}) begin
                              failed = 1'b1; job.st = ST_OFFSET;
                           end else if (need > {1'b0, limit}) begin
                              failed = 1'b1; job.st = ST_LENGTH;
                           end else begin
                              coff_in = off[12:0]; cleft_in = len;
                              fi_in = ni_fi; ph_in = ni_ph;
                           end
                        end
                        default: begin
                           if (full) begin
                              failed = 1'b1; job.st = ST_FULL;
                           end else begin
                              job.emit = 1'b1; job.lit = it.data;
                              job.has_res = 1'b1; job.st = ST_BYTE;
                              wr_in = wr_ff + 1'b1; uc_in = uc_ff + 1'b1; cp_in = cp_inc;
                              if (cl_dec == '0) ph_in = PH_HDR_LO;
                           end
                        end
                     endcase
                     if (failed) begin
                        job.has_res = 1'b1;
                        if (it.last) clr = 1'b1; else err_in = 1'b1;
                     end else if (it.last) begin
                        if (cleft_in != '0) begin
                           ie_in = 1'b1;
                        end else begin
                           if (job.has_res) job.two = 1'b1;
                           else begin
                              job.has_res = 1'b1; job.st = ST_UNIT_END;
                           end
                           clr = 1'b1;
                        end
                     end
                  end
               end
            endcase
         end
      end
      if (clr) begin
         uc_in = '0; cp_in = '0; cl_in = '0; ph_in = PH_HDR_LO; fb_in = '0;
         fi_in = '0; tl_in = '0; coff_in = '0; cleft_in = '0; raw_in = 1'b0;
         err_in = 1'b0; ie_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; uc_ff <= '0; cp_ff <= '0; cl_ff <= '0; coff_ff <= '0;
         cleft_ff <= '0; ph_ff <= PH_HDR_LO; fb_ff <= '0; tl_ff <= '0; fi_ff <= '0;
         raw_ff <= 1'b0; err_ff <= 1'b0; ie_ff <= 1'b0;
      end else begin
         wr_ff <= wr_in; uc_ff <= uc_in; cp_ff <= cp_in; cl_ff <= cl_in;
         coff_ff <= coff_in; cleft_ff <= cleft_in; ph_ff <= ph_in; fb_ff <= fb_in;
         tl_ff <= tl_in; fi_ff <= fi_in; raw_ff <= raw_in; err_ff <= err_in; ie_ff <= ie_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/lznt_back.sv =====
// Back end: history memory with forwarding, and the result queue.
`default_nettype none
module lznt_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  lznt_pkg::job_type       job,
   output logic                    room,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [7:0]              rsp_out_byte,
   output logic [2:0]              rsp_status
);
   import lznt_pkg::*;

   localparam int PW = $clog2(OQ_DEPTH);

   typedef struct packed {
      logic [7:0] data;
      logic [2:0] st;
      logic       two;
   } entry_type;

   logic [7:0]         hist_mem [HIST_DEPTH];
   job_type            bk_ff;
   logic [7:0]         rd_ff;
   logic               fw_v_ff;
   logic [HIST_AW-1:0] fw_a_ff;
   logic [7:0]         fw_d_ff;

   entry_type          q_ff [OQ_DEPTH];
   logic [PW-1:0]      wp_ff, rp_ff;
   logic [PW:0]        cnt_ff, cnt_in;
   logic               sub_ff;
   logic [7:0]         mem_byte, byte_val;
   logic               push, pop, adv;
   entry_type          head;

   assign mem_byte = (fw_v_ff && fw_a_ff == bk_ff.rd_addr) ? fw_d_ff : rd_ff;
   assign byte_val = bk_ff.from_mem ? mem_byte : bk_ff.lit;
   assign push     = bk_ff.valid && bk_ff.has_res;

   always_ff @(posedge clock) begin
      if (bk_ff.valid && bk_ff.emit) hist_mem[bk_ff.wr_addr] <= byte_val;
      rd_ff   <= hist_mem[job.rd_addr];
      fw_a_ff <= bk_ff.wr_addr;
      fw_d_ff <= byte_val;
   end

   always_ff @(posedge clock) begin
      if (reset) bk_ff <= '0;
      else bk_ff <= job;
   end

   always_ff @(posedge clock) begin
      if (reset) fw_v_ff <= 1'b0;
      else fw_v_ff <= bk_ff.valid && bk_ff.emit;
   end

   // result queue, one entry per item that has a result, possibly two transfers
   assign head         = q_ff[rp_ff];
   assign rsp_empty    = (cnt_ff == '0);
   assign pop          = rsp_pop && !rsp_empty;
   assign adv          = pop && (sub_ff || !head.two);
   assign rsp_out_byte = sub_ff ? 8'd0 : ((head.st == ST_BYTE) ? head.data : 8'd0);
   assign rsp_status   = sub_ff ? ST_UNIT_END : head.st;
   assign room         = (cnt_ff + (PW+1)'(push)) < (PW+1)'(OQ_DEPTH);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !adv) cnt_in = cnt_ff + 1'b1;
      else if (!push && adv) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; sub_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= wp_ff + 1'b1;
         if (adv) rp_ff <= rp_ff + 1'b1;
         if (pop) sub_ff <= !adv;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= '{data: byte_val, st: bk_ff.st, two: bk_ff.two};
   end

endmodule
`default_nettype wire

// ===== hw/rtl/lznt1_decompressor_core.sv =====
// Top level of the streaming LZNT1 decompressor.
//
// Input channel (req_*): push/full queue. Each transfer is a compressed byte
// (req_func 0) or a pull tick (req_func 1) that emits one pending copy byte.
// req_in_last marks the final compressed byte of a compression unit.
// Result channel (rsp_*): empty/pop queue of {out_byte, status}; status 0 is
// a decompressed byte, 1 unit end, 2..7 errors (byte then reads zero).
// An item gives zero, one or two result transfers; a second one follows
// on the next pop.
// csr_write_* sets the unit size limit (reset 65536); write it while idle.
// Throughput: one item per cycle while the result queue has room, set by
// the single parse engine and the one-write/one-read history RAM (reads
// are forwarded from the last write). A result passes the input queue
// register, the back-end register and then the result queue before it shows.
// Reset clears both queues and the parse state; history contents are kept
// undefined until written. When the receiver stalls, the result queue fills,
// the engine stops and req_full rises once the input queue is full.
`default_nettype none
module lznt1_decompressor_core #(
   parameter int MAX_UNIT_BYTES = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic [2:0]       rsp_status,
   input  wire logic        csr_write_enable,
   input  wire logic [16:0] csr_write_data
);
   import lznt_pkg::*;

   localparam int LIM_W = $clog2(MAX_UNIT_BYTES + 1);
   localparam int CW    = ((LIM_W > 17) ? LIM_W : 17) + 1;

   logic [16:0]    unit_size_ff;
   logic [CW-1:0]  limit;
   logic           item_valid, fire, room;
   item_type       item;
   job_type        job;

   // unit size register, clamped to the build-time maximum
   always_ff @(posedge clock) begin
      if (reset) unit_size_ff <= 17'h10000;
      else if (csr_write_enable) unit_size_ff <= csr_write_data;
   end

   assign limit = (CW'(unit_size_ff) > CW'(MAX_UNIT_BYTES)) ?
                  CW'(MAX_UNIT_BYTES) : CW'(unit_size_ff);

   // engine runs whenever an item waits and the result queue has space
   assign fire = item_valid && room;

   lznt_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_func(req_func),
      .req_in_byte(req_in_byte), .req_in_last(req_in_last),
      .item_valid(item_valid), .item(item), .item_take(fire)
   );

   lznt_engine #(.CW(CW)) u_engine (
      .clock(clock), .reset(reset), .fire(fire), .it(item),
      .limit(limit), .job(job)
   );

   lznt_back u_back (
      .clock(clock), .reset(reset), .job(job), .room(room),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_byte(rsp_out_byte), .rsp_status(rsp_status)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/lznt_checker.sv =====
// Port-level checks for the decompressor core, bound to the top level.
`default_nettype none
module lznt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_full,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [7:0] rsp_out_byte,
   input wire logic [2:0] rsp_status
);
   import lznt_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input queue full after reset");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_BYTE) |-> rsp_out_byte == 8'd0)
      else $error("non-byte result carries data");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
      (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind lznt1_decompressor_core lznt_checker u_lznt_checker (
   .clock(clock), .reset(reset), .req_full(req_full), .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop), .rsp_out_byte(rsp_out_byte), .rsp_status(rsp_status)
);
`default_nettype wire
